[hdl/context_switch_slice_builder_core_assert.svh]
// Assertion macros used by the slice builder RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef CONTEXT_SWITCH_SLICE_BUILDER_CORE_ASSERT_SVH
`define CONTEXT_SWITCH_SLICE_BUILDER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge of clk_i while out of reset.
`define CSSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define CSSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CSSB_ASSERT(lbl, prop, msg)
`define CSSB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hdl/cssb_pkg.sv]
`timescale 1ns / 1ps

package cssb_pkg;

  // Field widths fixed by the event format.
  localparam int unsigned ThreadW = 32;
  localparam int unsigned ProcessW = 32;
  localparam int unsigned CpuW = 6;
  localparam int unsigned StampW = 64;

  // Event kinds.
  typedef enum logic {
    CMD_MAP    = 1'b0,
    CMD_SWITCH = 1'b1
  } cmd_e;

  // Request to the thread map: an optional write and the lookup key.
  typedef struct packed {
    logic                write;
    logic [ThreadW-1:0]  key;
    logic [ProcessW-1:0] process;
  } map_req_t;

  // Lookup answer from the thread map.
  typedef struct packed {
    logic                hit;
    logic [ProcessW-1:0] process;
  } map_rsp_t;

  // What the core table keeps for each core.
  typedef struct packed {
    logic [ThreadW-1:0] thread;
    logic [StampW-1:0]  stamp;
  } core_entry_t;

endpackage

[hdl/cssb_thread_map.sv]
`timescale 1ns / 1ps

// Thread-to-process CAM. Slots fill in order and are never freed, so a fill
// pointer plus a full flag stands in for per-slot valid bits. Once full, the
// fill pointer doubles as the round robin replacement pointer.
module cssb_thread_map
  import cssb_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output map_rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(MAP_ENTRIES);

  logic [ThreadW-1:0]  thread_q  [MAP_ENTRIES];
  logic [ProcessW-1:0] process_q [MAP_ENTRIES];
  logic [IdxW-1:0]     ptr_q, ptr_d;
  logic                full_q, full_d;

  logic [MAP_ENTRIES-1:0] hit;
  logic                   any_hit;
  logic [ProcessW-1:0]    hit_process;

  // Parallel match of the key against every occupied slot.
  always_comb begin
    hit_process = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      hit[i] = (full_q || (IdxW'(i) < ptr_q)) && (thread_q[i] == req_i.key);
      if (hit[i]) begin
        hit_process = hit_process | process_q[i];
      end
    end
    any_hit = |hit;
  end

  assign rsp_o.hit     = any_hit;
  assign rsp_o.process = hit_process;

  // A known thread gets its process overwritten; a new one takes the pointer slot.
  always_ff @(posedge clk_i) begin
    if (req_i.write) begin
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        if (hit[i]) begin
          process_q[i] <= req_i.process;
        end else if (!any_hit && (IdxW'(i) == ptr_q)) begin
          thread_q[i]  <= req_i.key;
          process_q[i] <= req_i.process;
        end
      end
    end
  end

  // Fill and replacement pointer, wrapping at the last slot.
  always_comb begin
    ptr_d  = ptr_q;
    full_d = full_q;
    if (req_i.write && !any_hit) begin
      if (ptr_q == IdxW'(MAP_ENTRIES - 1)) begin
        ptr_d  = '0;
        full_d = 1'b1;
      end else begin
        ptr_d = ptr_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      full_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      full_q <= full_d;
    end
  end

endmodule

[hdl/cssb_core_table.sv]
`timescale 1ns / 1ps

// Per-core record of the last switch. The entry memory is read when a word
// is accepted, with a bypass from the update in flight to the same core, so
// the registered read data is current when the word reaches the work stage.
module cssb_core_table
  import cssb_pkg::*;
#(
  parameter int unsigned CORES = 64
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         fetch_en_i,
  input  logic [((CORES > 1) ? $clog2(CORES) : 1)-1:0] fetch_idx_i,
  output core_entry_t                                  fetch_data_o,
  input  logic                                         upd_en_i,
  input  logic [((CORES > 1) ? $clog2(CORES) : 1)-1:0] upd_idx_i,
  input  core_entry_t                                  upd_data_i,
  output logic                                         seen_o
);

  core_entry_t      mem_q [CORES];
  core_entry_t      fetch_q;
  logic [CORES-1:0] seen_q;

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      mem_q[upd_idx_i] <= upd_data_i;
    end
    if (fetch_en_i) begin
      if (upd_en_i && (fetch_idx_i == upd_idx_i)) begin
        fetch_q <= upd_data_i;
      end else begin
        fetch_q <= mem_q[fetch_idx_i];
      end
    end
  end

  assign fetch_data_o = fetch_q;

  // Seen bits, cleared by reset, guard the uninitialized entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (upd_en_i) begin
      seen_q[upd_idx_i] <= 1'b1;
    end
  end

  assign seen_o = seen_q[upd_idx_i];

endmodule

[hdl/context_switch_slice_builder_core.sv]
`timescale 1ns / 1ps
// A slice reaches the result ports through the input register and then the result register.
// Throughput: one word per cycle; busy_o is never raised and there is no result backpressure.
// The per-core memory read at accept time and the map CAM match in the work stage set the rate.
// Reset clears the core seen bits, the map fill pointer and the pipeline valids at once.
// Table contents are not cleared, so no clearing pass follows reset.
`include "context_switch_slice_builder_core_assert.svh"

module context_switch_slice_builder_core
  import cssb_pkg::*;
#(
  parameter int unsigned CORES = 64,
  parameter int unsigned MAP_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                command_i,
  input  logic [ThreadW-1:0]  thread_id_i,
  input  logic [ProcessW-1:0] process_id_i,
  input  logic [CpuW-1:0]     cpu_i,
  input  logic [ThreadW-1:0]  old_thread_i,
  input  logic [ThreadW-1:0]  new_thread_i,
  input  logic [StampW-1:0]   timestamp_ns_i,
  output logic                result_valid_o,
  output logic [ProcessW-1:0] slice_process_o,
  output logic                process_known_o,
  output logic [ThreadW-1:0]  slice_thread_o,
  output logic [CpuW-1:0]     slice_core_o,
  output logic [StampW-1:0]   duration_ns_o,
  output logic [StampW-1:0]   out_time_ns_o
);

  localparam int unsigned CoreIdxW = $clog2(CORES + 1);
  localparam int unsigned TabIdxW = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int unsigned CmpW = ((CoreIdxW > CpuW) ? CoreIdxW : CpuW) + 1;

  logic accept;

  // Input register.
  logic                valid_q;
  cmd_e                cmd_q;
  logic [ThreadW-1:0]  thread_id_q;
  logic [ProcessW-1:0] process_id_q;
  logic [CpuW-1:0]     cpu_q;
  logic [ThreadW-1:0]  old_thread_q;
  logic [ThreadW-1:0]  new_thread_q;
  logic [StampW-1:0]   stamp_q;

  // Work stage.
  logic [CmpW-1:0]     cpu_in_ext, cpu_q_ext;
  logic                in_range;
  logic                sw_event;
  logic                seen;
  core_entry_t         prev;
  core_entry_t         upd_entry;
  map_req_t            map_req;
  map_rsp_t            map_rsp;
  logic [StampW:0]     delta;
  logic                emit;

  // Result register.
  logic                result_valid_q;
  logic [ProcessW-1:0] slice_process_q;
  logic                process_known_q;
  logic [ThreadW-1:0]  slice_thread_q;
  logic [CpuW-1:0]     slice_core_q;
  logic [StampW-1:0]   duration_q;
  logic [StampW-1:0]   out_time_q;

  // Every cycle is open for a new word.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Capture the accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q        <= cmd_e'(command_i);
      thread_id_q  <= thread_id_i;
      process_id_q <= process_id_i;
      cpu_q        <= cpu_i;
      old_thread_q <= old_thread_i;
      new_thread_q <= new_thread_i;
      stamp_q      <= timestamp_ns_i;
    end
  end

  // Core index and range check; cores at or above CORES are ignored.
  assign cpu_in_ext = CmpW'(cpu_i);
  assign cpu_q_ext  = CmpW'(cpu_q);
  assign in_range   = cpu_q_ext < CmpW'(CORES);
  assign sw_event   = valid_q && (cmd_q == CMD_SWITCH) && in_range;

  assign upd_entry.thread = new_thread_q;
  assign upd_entry.stamp  = stamp_q;

  cssb_core_table #(
    .CORES(CORES)
  ) u_core_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fetch_en_i  (accept),
    .fetch_idx_i (cpu_in_ext[TabIdxW-1:0]),
    .fetch_data_o(prev),
    .upd_en_i    (sw_event),
    .upd_idx_i   (cpu_q_ext[TabIdxW-1:0]),
    .upd_data_i  (upd_entry),
    .seen_o      (seen)
  );

  // One CAM serves both the mapping write and the slice lookup. On a slice
  // the leaving thread equals the one recorded, so it is the lookup key.
  assign map_req.write   = valid_q && (cmd_q == CMD_MAP);
  assign map_req.key     = (cmd_q == CMD_SWITCH) ? old_thread_q : thread_id_q;
  assign map_req.process = process_id_q;

  cssb_thread_map #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_thread_map (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (map_req),
    .rsp_o (map_rsp)
  );

  // Duration and the backwards-time check share one subtraction.
  assign delta = {1'b0, stamp_q} - {1'b0, prev.stamp};
  assign emit  = sw_event && seen && (prev.thread == old_thread_q) && !delta[StampW];

  // Result register: the strobe lasts exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      slice_process_q <= map_rsp.hit ? map_rsp.process : '0;
      process_known_q <= map_rsp.hit;
      slice_thread_q  <= old_thread_q;
      slice_core_q    <= cpu_q;
      duration_q      <= delta[StampW-1:0];
      out_time_q      <= stamp_q;
    end
  end

  assign result_valid_o  = result_valid_q;
  assign slice_process_o = slice_process_q;
  assign process_known_o = process_known_q;
  assign slice_thread_o  = slice_thread_q;
  assign slice_core_o    = slice_core_q;
  assign duration_ns_o   = duration_q;
  assign out_time_ns_o   = out_time_q;

  // A slice only follows a switch word that was in the work stage.
  `CSSB_ASSERT(a_slice_from_switch, result_valid_o |-> $past(sw_event), "slice without a switch")
  // An unknown process is reported as zero.
  `CSSB_ASSERT(a_unknown_zero, result_valid_o && !process_known_o |-> slice_process_o == '0,
               "unknown process not zero")
  // The duration never exceeds the switch-out time.
  `CSSB_ASSERT(a_duration_bound, result_valid_o |-> duration_ns_o <= out_time_ns_o,
               "duration exceeds end time")
  // No slice can be reported in the cycle after reset is released or during it.
  `CSSB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !result_valid_o, "slice out of reset")

endmodule
